// ===== design/sird_pkg.sv =====
// ----------------------------------------------------------------------------
// sird_pkg: shared types and constants for signed integer to radix digits
// Widths, register indexes, character codes and alphabet helpers.
// ----------------------------------------------------------------------------
package sird_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int MAX_BASE     = 40;
  localparam int MIN_BASE     = 2;
  localparam int ALPHA_WORDS  = 5;
  localparam int ALPHA_CHARS  = 40;
  localparam int CHAR_W       = 8;
  localparam int ALPHA_WORD_W = 64;
  localparam int DIGIT_W      = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = ALPHA_WORD_W;

  // divider: quotient bits resolved per cycle
  localparam int SUB_STEPS  = 8;
  localparam int DIV_CYCLES = VALUE_WIDTH / SUB_STEPS;
  localparam int SUB_CNT_W  = $clog2(DIV_CYCLES);
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
  localparam int STK_IDX_W  = $clog2(VALUE_WIDTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT       = 3'd6;

  localparam logic [DIGIT_W-1:0]      BASE_LENGTH_RESET = 6'd10;
  localparam logic [ALPHA_WORD_W-1:0] ALPHA_RESET_0     = 64'h3736_3534_3332_3130;
  localparam logic [ALPHA_WORD_W-1:0] ALPHA_RESET_1     = 64'h0000_0000_0000_3938;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef logic [ALPHA_WORDS-1:0][ALPHA_WORD_W-1:0] alpha_words_t;
  typedef logic [ALPHA_CHARS-1:0][CHAR_W-1:0]       alpha_chars_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] base_length;
    alpha_words_t       words;
  } cfg_t;

  // one queued word: sign and magnitude
  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } work_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] digit_count;
  } back_stat_t;

  function automatic logic char_allowed(logic [CHAR_W-1:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ) ||
           (c >= CHAR_LA && c <= CHAR_LZ);
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char(alpha_words_t w, logic [DIGIT_W-1:0] k);
    logic [ALPHA_WORD_W-1:0] word;
    word = '0;
    for (int i = 0; i < ALPHA_WORDS; i++) begin
      if (k[DIGIT_W-1:3] == 3'(i)) begin
        word = w[i];
      end
    end
    return word[{k[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

// ===== design/sird_front.sv =====
// ----------------------------------------------------------------------------
// sird_front: config registers, alphabet check, input intake
// Holds the alphabet, sweeps it for validity after each write, and turns
// each value accepted with a valid alphabet into a queued sign and magnitude.
// ----------------------------------------------------------------------------
module sird_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [sird_pkg::VALUE_WIDTH-1:0] value,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0]      cfg_data,
  output sird_pkg::cfg_t                       cfg,
  output logic                                 push,
  output sird_pkg::work_t                      push_word,
  input  logic                                 full,
  output logic                                 chk_busy
);
  import sird_pkg::*;

  typedef enum logic [1:0] {CHK_IDLE, CHK_LOAD, CHK_RUN} chk_state_t;

  chk_state_t          state;
  logic [DIGIT_W-1:0]  base_length;
  alpha_words_t        words;
  logic                alpha_valid;
  alpha_chars_t        shadow;
  alpha_chars_t        shadow_next;
  logic [DIGIT_W-1:0]  rem;
  logic                ok;
  logic                step_ok;
  logic [VALUE_WIDTH-1:0] v;

  // head of shadow vs. the remaining later characters
  always_comb begin
    logic dup;
    dup = 1'b0;
    for (int p = 1; p < ALPHA_CHARS; p++) begin
      dup = dup | ((DIGIT_W'(p) < rem) && (shadow[p] == shadow[0]));
    end
    step_ok = char_allowed(shadow[0]) && !dup;
    for (int p = 0; p < ALPHA_CHARS - 1; p++) begin
      shadow_next[p] = shadow[p + 1];
    end
    shadow_next[ALPHA_CHARS-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CHK_IDLE;
      alpha_valid <= 1'b1;
      base_length <= BASE_LENGTH_RESET;
      words       <= {{((ALPHA_WORDS - 2) * ALPHA_WORD_W){1'b0}}, ALPHA_RESET_1,
                      ALPHA_RESET_0};
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BASE_LENGTH) begin
          base_length <= cfg_data[DIGIT_W-1:0];
        end
        for (int w = 0; w < ALPHA_WORDS; w++) begin
          if (cfg_index == CFG_IDX_W'(REG_ALPHA_FIRST + w)) begin
            words[w] <= cfg_data;
          end
        end
      end
      if (cfg_we && cfg_index < REG_COUNT) begin
        state <= CHK_LOAD;
      end else begin
        unique case (state)
          CHK_IDLE: begin
          end
          CHK_LOAD: begin
            if (base_length < DIGIT_W'(MIN_BASE) || base_length > DIGIT_W'(MAX_BASE) ||
                base_length > DIGIT_W'(ALPHA_CHARS)) begin
              alpha_valid <= 1'b0;
              state       <= CHK_IDLE;
            end else begin
              shadow <= alpha_chars_t'(words);
              rem    <= base_length;
              ok     <= 1'b1;
              state  <= CHK_RUN;
            end
          end
          CHK_RUN: begin
            if (rem == '0) begin
              alpha_valid <= ok;
              state       <= CHK_IDLE;
            end else begin
              ok     <= ok && step_ok;
              shadow <= shadow_next;
              rem    <= rem - DIGIT_W'(1);
            end
          end
          default: state <= CHK_IDLE;
        endcase
      end
    end
  end

  assign v                = value;
  assign chk_busy         = (state != CHK_IDLE);
  assign in_stall         = chk_busy || full;
  assign push             = in_valid && !in_stall && alpha_valid;
  assign push_word.neg    = v[VALUE_WIDTH-1];
  assign push_word.mag    = v[VALUE_WIDTH-1] ? (~v + VALUE_WIDTH'(1)) : v;
  assign cfg.base_length  = base_length;
  assign cfg.words        = words;

endmodule

// ===== design/sird_queue.sv =====
// ----------------------------------------------------------------------------
// sird_queue: short FIFO between intake and conversion
// Two entries of sign and magnitude.
// ----------------------------------------------------------------------------
module sird_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sird_pkg::work_t push_word,
  output logic            full,
  input  logic            pop,
  output sird_pkg::work_t pop_word,
  output logic            empty
);
  import sird_pkg::*;

  work_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assign pop_word = entries[rd_ptr];
  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

endmodule

// ===== design/sird_back.sv =====
// ----------------------------------------------------------------------------
// sird_back: digit generation and character output
// Divides the magnitude by the radix, 8 quotient bits a cycle, pushes the
// remainders on a digit stack, then emits sign and digits MSB first.
// ----------------------------------------------------------------------------
module sird_back (
  input  logic                         clk,
  input  logic                         rst,
  input  sird_pkg::cfg_t               cfg,
  output logic                         pop,
  input  sird_pkg::work_t              pop_word,
  input  logic                         empty,
  output logic [sird_pkg::CHAR_W-1:0]  out_char,
  output logic                         last_char,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sird_pkg::back_stat_t         stat
);
  import sird_pkg::*;

  typedef enum logic [1:0] {BK_IDLE, BK_DIV, BK_EMIT} bk_state_t;

  bk_state_t              state;
  logic [VALUE_WIDTH-1:0] q;
  logic [DIGIT_W-1:0]     r;
  logic [SUB_CNT_W-1:0]   sub_cnt;
  logic [CNT_W-1:0]       cnt;
  logic                   neg_pend;
  logic [DIGIT_W-1:0]     stack [VALUE_WIDTH];

  logic [VALUE_WIDTH-1:0] q_w;
  logic [DIGIT_W-1:0]     r_w;
  logic [CNT_W-1:0]       cnt_inc;
  logic [STK_IDX_W-1:0]   rd_idx;
  logic                   take;

  // restoring division, SUB_STEPS bits per cycle
  always_comb begin
    logic [DIGIT_W:0] t;
    q_w = q;
    r_w = r;
    for (int k = 0; k < SUB_STEPS; k++) begin
      t = {r_w, q_w[VALUE_WIDTH-1]};
      if (t >= {1'b0, cfg.base_length}) begin
        r_w = DIGIT_W'(t - {1'b0, cfg.base_length});
        q_w = {q_w[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        r_w = t[DIGIT_W-1:0];
        q_w = {q_w[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign cnt_inc    = cnt + CNT_W'(1);
  assign rd_idx     = STK_IDX_W'(cnt - CNT_W'(1));
  assign take       = !out_valid || !out_stall;
  assign pop        = (state == BK_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // in BK_EMIT the output register is reloaded or held below
      if (out_valid && !out_stall && state != BK_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          if (!empty) begin
            q        <= pop_word.mag;
            neg_pend <= pop_word.neg;
            r        <= '0;
            sub_cnt  <= '0;
            cnt      <= '0;
            state    <= BK_DIV;
          end
        end
        BK_DIV: begin
          q       <= q_w;
          r       <= r_w;
          sub_cnt <= sub_cnt + SUB_CNT_W'(1);
          if (sub_cnt == SUB_CNT_W'(DIV_CYCLES - 1)) begin
            stack[cnt[STK_IDX_W-1:0]] <= r_w;
            cnt <= cnt_inc;
            r   <= '0;
            if (q_w == '0 || cnt_inc == CNT_W'(VALUE_WIDTH)) begin
              state <= BK_EMIT;
            end
          end
        end
        BK_EMIT: begin
          if (take) begin
            out_valid <= 1'b1;
            if (neg_pend) begin
              out_char  <= CHAR_MINUS;
              last_char <= 1'b0;
              neg_pend  <= 1'b0;
            end else begin
              out_char  <= alpha_char(cfg.words, stack[rd_idx]);
              last_char <= (cnt == CNT_W'(1));
              cnt       <= cnt - CNT_W'(1);
              if (cnt == CNT_W'(1)) begin
                state <= BK_IDLE;
              end
            end
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  assign stat.busy        = (state != BK_IDLE);
  assign stat.digit_count = cnt;

endmodule

// ===== design/signed_integer_to_radix_digits_top.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_top: signed value to text in a set radix
// Front intake and alphabet check, two-word queue, divider and emitter.
// ----------------------------------------------------------------------------
// Each accepted 32-bit two's complement value comes out as a run of
// character words: '-' first when negative, then the digits of the
// magnitude (most negative value included) most significant first, with
// last_char set on the final one. Zero gives the single alphabet character
// for digit 0. The radix is base_length and the digits are taken from the
// alphabet registers (reset: decimal "0123456789"). The alphabet is valid
// with 2..40 characters from 0-9, A-Z, a-z and none repeated; while it is
// invalid, values are accepted and dropped with no output. After any
// register write the front sweeps the alphabet, one character a cycle,
// and holds in_stall while it loads and sweeps (only while it loads when
// base_length is out of range). Per value the back pops it from the queue,
// divides the magnitude by the radix digit by digit (8 quotient bits a
// cycle over the 32-bit magnitude), then puts out one character a cycle
// while out_stall is low. The two-word queue lets the front take new
// values while the back is still converting or its last word waits.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic signed [sird_pkg::VALUE_WIDTH-1:0] value,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  output logic [sird_pkg::CHAR_W-1:0]             out_char,
  output logic                                    last_char,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic                                    cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import sird_pkg::*;

  cfg_t       cfg;
  work_t      push_word;
  work_t      pop_word;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  logic       chk_busy;
  back_stat_t bk_stat;

  // intake, config registers, alphabet sweep
  sird_front u_front (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .chk_busy  (chk_busy)
  );

  // decouples intake from conversion
  sird_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .empty     (q_empty)
  );

  // divider, digit stack, output register
  sird_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .empty     (q_empty),
    .out_char  (out_char),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (bk_stat)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    bk_stat.digit_count <= CNT_W'(VALUE_WIDTH))
    else $error("digit count past stack depth");

  a_no_push_in_check: assert property (@(posedge clk) disable iff (rst)
    chk_busy |-> !q_push)
    else $error("word queued during alphabet sweep");

endmodule

// ===== tb/signed_integer_to_radix_digits_top_test.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_top_test: self-checking bench for radix text
// Drives signed values under many alphabets and checks every character word
// against a cycle-free software conversion kept in step with the registers.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_top_test;
  import sird_pkg::*;

  // One character word of expected text.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // Quiet time before a register write. A value dropped under an illegal
  // alphabet leaves no trace in the output, and a legal one may still be in
  // the back with two queued words behind it, so be generous.
  localparam int QUIET_CYCLES = 400;
  // Slowest legal run: ~260 values of 33 words, each word held up by stall runs
  // of the sink, plus divider time, sender gaps and quiet time, taken several
  // times over.
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int REPORT_CAP   = 40;
  // Values sent in the random phases; with the directed tests about 260 in all.
  localparam int RANDOM_ITEMS = 235;
  // Index past the last real register: writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_COUNT + 3'd1;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic signed [VALUE_WIDTH-1:0] value     = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [CHAR_W-1:0]             out_char;
  logic                          last_char;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data  = '0;

  // Shadow of the register file and the derived alphabet check.
  logic [DIGIT_W-1:0] radix_len = BASE_LENGTH_RESET;
  alpha_words_t       alpha     = {64'h0, 64'h0, 64'h0, ALPHA_RESET_1, ALPHA_RESET_0};
  logic               alpha_ok  = 1'b1;

  text_char_t pending_text[$];
  int         mismatch_count = 0;
  int         cycles;
  int         sink_left = 0;

  signed_integer_to_radix_digits_top dut (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_char  (out_char),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic is_alnum_char(logic [CHAR_W-1:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ) ||
           (c >= CHAR_LA && c <= CHAR_LZ);
  endfunction

  function automatic logic [CHAR_W-1:0] glyph_at(int k);
    return alpha[k >> 3][(k & 7) * CHAR_W +: CHAR_W];
  endfunction

  // Legal: 2..40 characters, all digits or letters, no repeats in the used part.
  function automatic logic alphabet_is_legal();
    int                n;
    logic [CHAR_W-1:0] c;
    n = radix_len;
    if (n < MIN_BASE || n > MAX_BASE || n > ALPHA_CHARS) return 1'b0;
    for (int i = 0; i < n; i++) begin
      c = glyph_at(i);
      if (!is_alnum_char(c)) return 1'b0;
      for (int j = i + 1; j < n; j++) begin
        if (glyph_at(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queue up the text of one accepted value: sign, then digits MS first.
  task automatic predict_text(input logic signed [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] mag;
    logic [DIGIT_W-1:0]     digits[VALUE_WIDTH];
    int                     n;
    if (!alpha_ok) return;
    mag = v;
    if (v[VALUE_WIDTH-1]) mag = ~mag + 1'b1;  // most negative stays 2^31 unsigned
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % radix_len);
      mag = mag / radix_len;
      n++;
    end while (mag != 0 && n < VALUE_WIDTH);
    if (v[VALUE_WIDTH-1]) pending_text.push_back('{ch: CHAR_MINUS, last: 1'b0});
    for (int k = n - 1; k >= 0; k--) begin
      pending_text.push_back('{ch: glyph_at(digits[k]), last: (k == 0)});
    end
  endtask

  // --------------------------------------------------------------------------
  // Pacing
  // --------------------------------------------------------------------------

  // Mostly back to back, often short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sink: random runs of flow and stall; flow runs give stall-free stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      sink_left <= 0;
    end else if (sink_left != 0) begin
      sink_left <= sink_left - 1;
    end else if ($urandom_range(0, 1) != 0) begin
      out_stall <= 1'b0;
      sink_left <= $urandom_range(1, 30);
    end else begin
      out_stall <= 1'b1;
      sink_left <= pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Checking: each word taken by the sink against the oldest expected word
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : check_text
    text_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_text.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: unexpected word, expected none, got char %h last %b",
                   $time, out_char, last_char);
      end else begin
        want = pending_text.pop_front();
        if (out_char !== want.ch) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: out_char mismatch, expected %h, got %h", $time, want.ch, out_char);
        end
        if (last_char !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: last_char mismatch, expected %b, got %b",
                     $time, want.last, last_char);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one value, hold it through stalls, predict on acceptance. With a zero
  // gap valid stays up; whoever comes next either drives a new value or drops it.
  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
    int gap;
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_text(v);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      value    <= $urandom();  // idle bus noise
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every expected word has come out.
  task automatic wait_text_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_text.size() != 0) @(posedge clk);
  endtask

  task automatic wait_for_quiet();
    wait_text_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Single write; only called with the block idle. Shadow follows on the edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= {$urandom(), $urandom()};
    if (idx == REG_BASE_LENGTH) begin
      radix_len = data[DIGIT_W-1:0];
    end else if (idx >= REG_ALPHA_FIRST && idx < REG_COUNT) begin
      alpha[idx - REG_ALPHA_FIRST] = data;
    end
    alpha_ok = alphabet_is_legal();
  endtask

  // Full reload: length (junk in the unused high bits) and all five words.
  task automatic load_alphabet(input logic [DIGIT_W-1:0] len, input alpha_chars_t chars);
    logic [CFG_DATA_W-1:0] data;
    alpha_words_t          words;
    wait_for_quiet();
    data = {$urandom(), $urandom()};
    data[DIGIT_W-1:0] = len;
    write_reg(REG_BASE_LENGTH, data);
    words = chars;
    for (int w = 0; w < ALPHA_WORDS; w++) begin
      write_reg(REG_ALPHA_FIRST + CFG_IDX_W'(w), words[w]);
    end
  endtask

  // Characters past the string are random junk the block must not look at.
  task automatic set_alphabet(input string s, input int len);
    alpha_chars_t chars;
    for (int k = 0; k < ALPHA_CHARS; k++) chars[k] = CHAR_W'($urandom());
    for (int k = 0; k < s.len() && k < ALPHA_CHARS; k++) chars[k] = s[k];
    load_alphabet(DIGIT_W'(len), chars);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset alphabet is decimal; no writes before this one.
  task automatic test_reset_decimal();
    send_value(0);
    send_value(7);
    send_value(-1);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(1000000000);
  endtask

  // Radix 2: most negative value gives the longest text, '-' plus 32 digits.
  task automatic test_binary_extremes();
    set_alphabet("01", 2);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    send_value(1);
    send_value(0);
  endtask

  // Letters at both ends of each range; base 40 is the widest legal alphabet.
  task automatic test_wide_alphabets();
    set_alphabet("0123456789abcdefghijklmnopqrstuvwxyz", 36);
    send_value(35);
    send_value(-36);
    send_value(32'sh7FFF_FFFF);
    set_alphabet("zZaA09BCDEFGHIJKLMNOPQRSTUVWXYbcdefghijk", 40);
    send_value(39);
    send_value(-40);
    send_value(32'sh8000_0000);
    send_value(0);  // zero is the first alphabet character alone
  endtask

  // Illegal alphabets: values are taken and dropped without a word out.
  task automatic test_rejected_alphabets();
    set_alphabet("0123456789", 1);
    send_value(5);
    set_alphabet("0123456789", 0);
    send_value(-5);
    set_alphabet("zZaA09BCDEFGHIJKLMNOPQRSTUVWXYbcdefghijk", 41);
    send_value(12345);
    set_alphabet("0123456789", 63);
    send_value(-2);
    set_alphabet("0120", 4);
    send_value(9);
    set_alphabet("01{3", 4);
    send_value(-77);
  endtask

  // Writes past the last register must leave a legal decimal setup alone.
  task automatic test_ignored_registers();
    set_alphabet("0123456789", 10);
    write_reg(REG_COUNT, {$urandom(), $urandom()});
    write_reg(REG_SPARE, 64'h0);
    send_value(42);
    send_value(-907);
  endtask

  // Random legal alphabet of random length, optionally broken one way.
  task automatic load_random_alphabet(input bit legal);
    logic [CHAR_W-1:0] pool[$];
    logic [CHAR_W-1:0] tmp;
    logic [CHAR_W-1:0] bad;
    alpha_chars_t      chars;
    int                len;
    int                i;
    int                j;
    int                r;
    for (int c = 0; c < 256; c++) begin
      if (is_alnum_char(CHAR_W'(c))) pool.push_back(CHAR_W'(c));
    end
    for (int k = pool.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = pool[k];
      pool[k] = pool[j];
      pool[j] = tmp;
    end
    r = $urandom_range(0, 9);
    if (r < 3) len = $urandom_range(2, 4);
    else if (r < 7) len = $urandom_range(5, 16);
    else len = $urandom_range(17, ALPHA_CHARS);
    for (int k = 0; k < ALPHA_CHARS; k++) begin
      chars[k] = (k < len) ? pool[k] : CHAR_W'($urandom());
    end
    if (!legal) begin
      i = $urandom_range(0, len - 1);
      case ($urandom_range(0, 2))
        0: begin
          len = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1) : $urandom_range(41, 63);
        end
        1: begin
          do j = $urandom_range(0, len - 1); while (j == i);
          chars[i] = chars[j];
        end
        default: begin
          // Bytes just outside each legal range, or any other non-alphanumeric.
          case ($urandom_range(0, 6))
            0: bad = CHAR_0 - 1'b1;
            1: bad = CHAR_9 + 1'b1;
            2: bad = CHAR_UA - 1'b1;
            3: bad = CHAR_UZ + 1'b1;
            4: bad = CHAR_LA - 1'b1;
            5: bad = CHAR_LZ + 1'b1;
            default: begin
              do bad = CHAR_W'($urandom()); while (is_alnum_char(bad));
            end
          endcase
          chars[i] = bad;
        end
      endcase
    end
    load_alphabet(DIGIT_W'(len), chars);
  endtask

  // Wide random values, small ones, range ends, radix powers and one less.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    longint unsigned p;
    int              k;
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: begin
        k = $urandom_range(0, 4 * radix_len + 4);
        return ($urandom_range(0, 1) != 0) ? -k : k;
      end
      3: begin
        case ($urandom_range(0, 5))
          0: return 0;
          1: return -1;
          2: return 32'sh8000_0000;
          3: return 32'sh7FFF_FFFF;
          4: return 32'sh8000_0001;
          default: return 1;
        endcase
      end
      default: begin
        if (radix_len < MIN_BASE) return $urandom();
        p = 1;
        k = $urandom_range(1, VALUE_WIDTH - 1);
        repeat (k) begin
          if (p * radix_len <= 64'h8000_0000) p = p * radix_len;
        end
        p = p - $urandom_range(0, 1);
        return ($urandom_range(0, 1) != 0) ? -VALUE_WIDTH'(p) : VALUE_WIDTH'(p);
      end
    endcase
  endfunction

  // Phases of random alphabets, legal and not, until RANDOM_ITEMS values are sent.
  task automatic test_random_traffic();
    int counted;
    int burst;
    int r;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 7) load_random_alphabet(1'b1);
      else if (r < 9) load_random_alphabet(1'b0);
      if ($urandom_range(0, 3) == 0) begin
        wait_for_quiet();
        write_reg(($urandom_range(0, 1) != 0) ? REG_COUNT : REG_SPARE,
                  {$urandom(), $urandom()});
      end
      burst = alpha_ok ? $urandom_range(15, 35) : $urandom_range(2, 6);
      for (int b = 0; b < burst && counted < RANDOM_ITEMS; b++) begin
        if ($urandom_range(0, 19) == 0) wait_text_drained();
        send_value(pick_value());
        counted++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_decimal();
    test_binary_extremes();
    test_wide_alphabets();
    test_rejected_alphabets();
    test_ignored_registers();
    test_random_traffic();
    wait_for_quiet();
    if (mismatch_count == 0 && pending_text.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog on a cycle count.
  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("%0t: timed out with %0d words outstanding", $time, pending_text.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sird_pkg.sv
design/sird_front.sv
design/sird_queue.sv
design/sird_back.sv
design/signed_integer_to_radix_digits_top.sv
tb/signed_integer_to_radix_digits_top_test.sv
